[sv/dcc_pkg.sv]
// Shared types and constants for the debounced click classifier.
// No dependencies; imported by every module of the block.
package dcc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_W         = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int QDEPTH        = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_CLICK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd3;

    localparam logic [CFG_W-1:0] CLICK_MIN_RST  = 32'd50;
    localparam logic [CFG_W-1:0] LONG_CLICK_RST = 32'd1000;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 32'd50;

    typedef enum logic [2:0] {
        EV_SHORT_DOWN   = 3'd0,
        EV_SHORT_UP     = 3'd1,
        EV_LONG_UP      = 3'd2,
        EV_STILL_HELD   = 3'd3,
        EV_LONG_DOWN    = 3'd4
    } t_event;

    typedef struct packed {
        logic             active_low;
        logic [CFG_W-1:0] click_min_ms;
        logic [CFG_W-1:0] long_click_ms;
        logic [CFG_W-1:0] debounce_ms;
    } t_cfg;

    // One queue entry carries all events of one poll: one or two.
    typedef struct packed {
        logic   two;
        t_event k0;
        t_event k1;
    } t_qent;

endpackage

[sv/dcc_front.sv]
// Front end: debounce and press classification, one poll per cycle while the queue is not full.
// Depends on dcc_pkg; pushes the events of each poll into dcc_queue.
module dcc_front #(
    parameter int TIME_BITS = dcc_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dcc_pkg::t_cfg               i_cfg,
    input  logic                        i_in_valid,
    input  logic                        i_raw_level,
    input  logic [31:0]                 i_now_ms,
    input  logic                        i_q_full,
    output logic                        o_in_stall,
    output logic                        o_push,
    output dcc_pkg::t_qent              o_ent
);
    import dcc_pkg::*;

    localparam int CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

    logic                 r_held, n_held;
    logic                 r_long, n_long;
    logic [TIME_BITS-1:0] r_last_change, n_last_change;
    logic [TIME_BITS-1:0] r_press_start, n_press_start;

    logic                 accept;
    logic                 pressed;
    logic                 debounce_ok;
    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] hold;
    logic [CMP_W-1:0]     hold_w;

    assign o_in_stall  = i_q_full;
    assign accept      = i_in_valid && !i_q_full;
    assign pressed     = i_raw_level ^ i_cfg.active_low;
    assign now_t       = TIME_BITS'(i_now_ms);
    assign since       = now_t - r_last_change;
    assign hold        = now_t - r_press_start;
    assign hold_w      = CMP_W'(hold);
    assign debounce_ok = CMP_W'(since) > CMP_W'(i_cfg.debounce_ms);

    always_comb begin
        n_held        = r_held;
        n_long        = r_long;
        n_last_change = r_last_change;
        n_press_start = r_press_start;
        o_push        = 1'b0;
        o_ent.two     = 1'b0;
        o_ent.k0      = EV_SHORT_DOWN;
        o_ent.k1      = EV_SHORT_DOWN;
        if (accept) begin
            if (pressed != r_held) begin
                if (debounce_ok) begin
                    n_last_change = now_t;
                    n_held        = pressed;
                    n_long        = 1'b0;
                    if (pressed) begin
                        n_press_start = now_t;
                        o_push        = 1'b1;
                        o_ent.k0      = EV_SHORT_DOWN;
                    end else if (hold_w >= CMP_W'(i_cfg.click_min_ms)) begin
                        o_push   = 1'b1;
                        o_ent.k0 = (hold_w < CMP_W'(i_cfg.long_click_ms)) ?
                                   EV_SHORT_UP : EV_LONG_UP;
                    end
                end
            end else if (pressed) begin
                o_push   = 1'b1;
                o_ent.k0 = EV_STILL_HELD;
                if (!r_long && hold_w >= CMP_W'(i_cfg.long_click_ms)) begin
                    n_long    = 1'b1;
                    o_ent.two = 1'b1;
                    o_ent.k1  = EV_LONG_DOWN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_long        <= 1'b0;
            r_last_change <= '0;
            r_press_start <= '0;
        end else begin
            r_held        <= n_held;
            r_long        <= n_long;
            r_last_change <= n_last_change;
            r_press_start <= n_press_start;
        end
    end

endmodule

[sv/dcc_queue.sv]
// Short event queue between front end and output stage.
// Depends on dcc_pkg for the entry type and depth.
module dcc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  dcc_pkg::t_qent i_data,
    input  logic           i_pop,
    output dcc_pkg::t_qent o_data,
    output logic           o_empty,
    output logic           o_full
);
    import dcc_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    t_qent            r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_count;

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/dcc_back.sv]
// Output stage: unpacks queue entries into single event words.
// Depends on dcc_pkg; pops from dcc_queue.
module dcc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  dcc_pkg::t_qent i_q_data,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [2:0]     o_event_kind,
    output logic           o_last_event
);
    import dcc_pkg::*;

    t_qent r_ent;
    logic  r_valid;
    logic  r_second;
    logic  take, done, load;

    assign take  = r_valid && !i_out_stall;
    assign done  = take && (!r_ent.two || r_second);
    assign load  = (!r_valid || done) && !i_q_empty;
    assign o_pop = load;

    assign o_out_valid  = r_valid;
    assign o_event_kind = r_second ? r_ent.k1 : r_ent.k0;
    assign o_last_event = !r_ent.two || r_second;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_ent <= i_q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid  <= 1'b1;
            r_second <= 1'b0;
        end else if (done) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= 1'b1;
        end
    end

endmodule

[sv/debounced_click_classifier_core.sv]
// Top level of the debounced click classifier: config registers, front end,
// event queue and output stage. Depends on dcc_pkg, dcc_front, dcc_queue, dcc_back.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+------------------------------
//  poll in  | i_in_valid  | o_in_stall  | i_raw_level, i_now_ms
//  event out| o_out_valid | i_out_stall | o_event_kind, o_last_event
//  config   | i_cfg_we    | none        | i_cfg_index, i_cfg_data
//
// One poll is taken per cycle while o_in_stall is low; its events are written
// into the queue and then loaded into the output register, one word per cycle
// while i_out_stall is low, so a poll with two events holds the output for both
// words. The four-entry queue sets how long polls keep coming while the output
// stalls; o_in_stall rises when it is full. Reset is synchronous; no clearing pass.
module debounced_click_classifier_core #(
    parameter int TIME_BITS = dcc_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_raw_level,
    input  logic [31:0]                    i_now_ms,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_event_kind,
    output logic                           o_last_event,
    input  logic                           i_cfg_we,
    input  logic [dcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [dcc_pkg::CFG_W-1:0]      i_cfg_data
);
    import dcc_pkg::*;

    t_cfg  r_cfg;
    t_qent f_ent;
    t_qent q_data;
    logic  f_push;
    logic  q_pop, q_empty, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low    <= 1'b0;
            r_cfg.click_min_ms  <= CLICK_MIN_RST;
            r_cfg.long_click_ms <= LONG_CLICK_RST;
            r_cfg.debounce_ms   <= DEBOUNCE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LOW: r_cfg.active_low    <= i_cfg_data[0];
                CFG_CLICK_MIN:  r_cfg.click_min_ms  <= i_cfg_data;
                CFG_LONG_CLICK: r_cfg.long_click_ms <= i_cfg_data;
                CFG_DEBOUNCE:   r_cfg.debounce_ms   <= i_cfg_data;
                default:        r_cfg               <= r_cfg;
            endcase
        end
    end

    dcc_front #(
        .TIME_BITS (TIME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_raw_level (i_raw_level),
        .i_now_ms    (i_now_ms),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (f_push),
        .o_ent       (f_ent)
    );

    dcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_ent),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    dcc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (q_empty),
        .i_q_data     (q_data),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_last_event (o_last_event)
    );

endmodule

[verif/debounced_click_classifier_core_tb.sv]
// Self-checking bench for debounced_click_classifier_core: polls go in, and a scoreboard
// predicts every event word and checks it as it leaves the block.
// Depends on dcc_pkg and the RTL of the block only.
module debounced_click_classifier_core_tb;

    import dcc_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    localparam int GAP_MAX       = 18;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;

    class click_scoreboard;
        logic        active_low;
        logic [31:0] click_min_ms;
        logic [31:0] long_click_ms;
        logic [31:0] debounce_ms;
        logic        held;
        logic [31:0] last_change_ms;
        logic [31:0] press_start_ms;
        logic        long_done;
        t_event      due_kind[$];
        logic        due_last[$];
        int          errors;
        int          kind_seen[5];

        function new();
            active_low     = 1'b0;
            click_min_ms   = CLICK_MIN_RST;
            long_click_ms  = LONG_CLICK_RST;
            debounce_ms    = DEBOUNCE_RST;
            held           = 1'b0;
            last_change_ms = '0;
            press_start_ms = '0;
            long_done      = 1'b0;
            errors         = 0;
            foreach (kind_seen[i]) kind_seen[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ACTIVE_LOW: active_low    = data[0];
                CFG_CLICK_MIN:  click_min_ms  = data;
                CFG_LONG_CLICK: long_click_ms = data;
                CFG_DEBOUNCE:   debounce_ms   = data;
                default: ;
            endcase
        endfunction

        function void note_poll(logic raw, logic [31:0] now_ms);
            t_event      kinds[2];
            int          n;
            logic        pressed;
            logic [31:0] since;
            logic [31:0] hold;
            n = 0;
            pressed = raw ^ active_low;
            if (pressed != held) begin
                since = now_ms - last_change_ms;
                if (since > debounce_ms) begin
                    last_change_ms = now_ms;
                    if (pressed) begin
                        press_start_ms = now_ms;
                        long_done      = 1'b0;
                        kinds[n]       = EV_SHORT_DOWN;
                        n++;
                    end else begin
                        hold = now_ms - press_start_ms;
                        if (hold >= click_min_ms) begin
                            if (hold < long_click_ms) kinds[n] = EV_SHORT_UP;
                            else kinds[n] = EV_LONG_UP;
                            n++;
                        end
                        long_done = 1'b0;
                    end
                    held = pressed;
                end
            end else if (pressed) begin
                hold = now_ms - press_start_ms;
                kinds[n] = EV_STILL_HELD;
                n++;
                if (!long_done && hold >= long_click_ms) begin
                    long_done = 1'b1;
                    kinds[n]  = EV_LONG_DOWN;
                    n++;
                end
            end
            for (int i = 0; i < n; i++) begin
                due_kind.insert(due_kind.size(), kinds[i]);
                due_last.insert(due_last.size(), i == n - 1);
            end
        endfunction

        function void check_event(logic [2:0] kind, logic last);
            t_event want_kind;
            logic   want_last;
            if (kind < 5) kind_seen[kind]++;
            if (due_kind.size() == 0) begin
                $error("event_kind: no word expected, actual %0d", kind);
                errors++;
                return;
            end
            want_kind = due_kind.pop_front();
            want_last = due_last.pop_front();
            if (kind !== want_kind) begin
                $error("event_kind mismatch: expected %0d, actual %0d", want_kind, kind);
                errors++;
            end
            if (last !== want_last) begin
                $error("last_event mismatch: expected %0d, actual %0d", want_last, last);
                errors++;
            end
        endfunction

        function int pending();
            return due_kind.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_raw_level;
    logic [31:0]          i_now_ms;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [2:0]           o_event_kind;
    logic                 o_last_event;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    click_scoreboard sb;
    logic [31:0]     clock_ms;
    logic            calm = 1'b0;
    int unsigned     polls_sent = 0;
    int unsigned     settings_done = 0;
    int unsigned     cycles = 0;

    debounced_click_classifier_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_raw_level  (i_raw_level),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_event_kind (o_event_kind),
        .o_last_event (o_last_event),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("debounced_click_classifier_core verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_event(o_event_kind, o_last_event);
    end

    initial begin
        int unsigned hold_off;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            hold_off = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (hold_off > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold_off) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_stall === 1'b0));
        end
    end

    task automatic send_poll(input logic raw, input logic [31:0] stamp);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_raw_level <= raw;
        i_now_ms    <= stamp;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_poll(raw, stamp);
        polls_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic set_config(input logic al, input logic [31:0] click_ms,
                              input logic [31:0] long_ms, input logic [31:0] deb_ms);
        wait_idle();
        cfg_write(CFG_ACTIVE_LOW, ($urandom & 32'hFFFF_FFFE) | al);
        cfg_write(CFG_CLICK_MIN, click_ms);
        cfg_write(CFG_LONG_CLICK, long_ms);
        cfg_write(CFG_DEBOUNCE, deb_ms);
        settings_done++;
    endtask

    task automatic click_sequence();
        logic [31:0] hold;
        logic [31:0] press_at;
        logic [31:0] stride;
        int unsigned polls;
        clock_ms = clock_ms + sb.debounce_ms + 1 + $urandom_range(0, 20);
        press_at = clock_ms;
        send_poll(~sb.active_low, clock_ms);
        case ($urandom_range(0, 2))
            0:       hold = $urandom_range(0, sb.click_min_ms);
            1:       hold = $urandom_range(sb.click_min_ms, sb.long_click_ms);
            default: hold = sb.long_click_ms + $urandom_range(0, 300);
        endcase
        polls  = $urandom_range(0, 6);
        stride = hold / (polls + 1);
        repeat (polls) begin
            clock_ms = clock_ms + stride;
            send_poll(~sb.active_low, clock_ms);
        end
        clock_ms = press_at + hold;
        send_poll(sb.active_low, clock_ms);
        if ($urandom_range(0, 1)) begin
            clock_ms = clock_ms + sb.debounce_ms + 1;
            send_poll(sb.active_low, clock_ms);
        end
    endtask

    task automatic bounce_burst();
        int unsigned n;
        logic        lvl;
        n   = $urandom_range(2, 6);
        lvl = 1'($urandom_range(0, 1));
        repeat (n) begin
            clock_ms = clock_ms + $urandom_range(0, sb.debounce_ms + 2);
            send_poll(lvl, clock_ms);
            lvl = ~lvl;
        end
    endtask

    task automatic noise_poll();
        case ($urandom_range(0, 3))
            0:       clock_ms = $urandom;
            1:       clock_ms = clock_ms - $urandom_range(1, 100);
            default: clock_ms = clock_ms + $urandom_range(0, 1500);
        endcase
        send_poll(1'($urandom_range(0, 1)), clock_ms);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop_at;
        int unsigned pause_at;
        int unsigned pick;
        logic        paused;
        stop_at  = polls_sent + count;
        pause_at = polls_sent + count / 2;
        paused   = 1'b0;
        while (polls_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0) calm = ~calm;
            pick = $urandom_range(0, 99);
            if (pick < 70) click_sequence();
            else if (pick < 85) bounce_burst();
            else noise_poll();
            if (!paused && polls_sent >= pause_at) begin
                wait_idle();
                paused = 1'b1;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_raw_level <= 1'b0;
        i_now_ms    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_ACTIVE_LOW;
        i_cfg_data  <= '0;
        clock_ms = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: bounce, press, hold, long press, clicks
        send_poll(1'b0, 32'd0);
        send_poll(1'b1, 32'd32);
        send_poll(1'b1, 32'd51);
        send_poll(1'b1, 32'd60);
        send_poll(1'b0, 32'd80);
        send_poll(1'b1, 32'd1051);
        send_poll(1'b1, 32'd1100);
        send_poll(1'b0, 32'd1200);
        send_poll(1'b1, 32'd1300);
        send_poll(1'b0, 32'd1330);
        send_poll(1'b0, 32'd1400);
        send_poll(1'b1, 32'd1500);
        send_poll(1'b0, 32'd1551);

        // no debounce: too-short release, timestamp wrap, backwards time
        set_config(1'b0, 32'd50, 32'd1000, 32'd0);
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b1, 32'h0000_0010);
        send_poll(1'b0, 32'h0000_0018);
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'h0000_0000);
        send_poll(1'b1, 32'h0000_0100);
        send_poll(1'b0, 32'h0000_00FF);
        send_poll(1'b1, 32'h8000_0000);
        send_poll(1'b1, 32'h8000_0000);

        // widest thresholds: only a hold of the full time span is a click
        set_config(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        clock_ms = 32'h1234_5678;
        send_poll(1'b0, clock_ms);
        send_poll(1'b1, clock_ms + 1);
        send_poll(1'b1, clock_ms);
        send_poll(1'b0, clock_ms);
        repeat (20) noise_poll();

        // widest debounce: no change is ever taken
        set_config(1'b1, 32'd0, 32'd0, 32'hFFFF_FFFF);
        repeat (20) noise_poll();

        set_config(1'b0, CLICK_MIN_RST, LONG_CLICK_RST, DEBOUNCE_RST);
        clock_ms = '0;
        run_random(120);
        set_config(1'b1, 32'd20, 32'd300, 32'd10);
        run_random(130);
        set_config(1'b0, 32'd0, 32'd0, 32'd0);
        run_random(100);
        repeat (2) begin
            set_config(1'($urandom_range(0, 1)), $urandom_range(0, 150),
                       $urandom_range(0, 800), $urandom_range(0, 60));
            run_random(130);
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("covered %0d polls under %0d register settings, checked by prediction",
                 polls_sent, settings_done + 1);
        $display("events: %0d short_down %0d short_up %0d long_up %0d still_held %0d long_down",
                 sb.kind_seen[EV_SHORT_DOWN], sb.kind_seen[EV_SHORT_UP],
                 sb.kind_seen[EV_LONG_UP], sb.kind_seen[EV_STILL_HELD],
                 sb.kind_seen[EV_LONG_DOWN]);
        if (sb.errors == 0) begin
            $display("debounced_click_classifier_core verification clean");
        end else begin
            $display("debounced_click_classifier_core verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
sv/dcc_pkg.sv
sv/dcc_front.sv
sv/dcc_queue.sv
sv/dcc_back.sv
sv/debounced_click_classifier_core.sv
verif/debounced_click_classifier_core_tb.sv
